// ===== rtl/rational_arithmetic_unit_defines.svh =====
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau: %s failed", "label");
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau: %s failed", "label");
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rau_pkg.sv =====
package rau_pkg;
  localparam int WORD_BITS = 32;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // datapath operation selected by the controller
  localparam logic [3:0] OP_LOAD    = 4'd0;
  localparam logic [3:0] OP_MUL1    = 4'd1;
  localparam logic [3:0] OP_MUL2    = 4'd2;
  localparam logic [3:0] OP_GCDINIT = 4'd3;
  localparam logic [3:0] OP_GCDSTEP = 4'd4;
  localparam logic [3:0] OP_DIVINIT = 4'd5;
  localparam logic [3:0] OP_DIVSTEP = 4'd6;
  localparam logic [3:0] OP_COMBINE = 4'd7;
  localparam logic [3:0] OP_PACK    = 4'd8;
  localparam logic [3:0] OP_IDLE    = 4'd9;
  localparam logic [3:0] OP_LDDEN   = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } sts_t;
endpackage

// ===== rtl/rau_datapath.sv =====
module rau_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rau_pkg::cmd_t        cmd,
  output rau_pkg::sts_t        sts,
  input  logic [2:0]           in_action,
  input  logic [31:0]          in_a_num,
  input  logic [31:0]          in_a_den,
  input  logic [31:0]          in_b_num,
  input  logic [31:0]          in_b_den,
  output logic [31:0]          res_num,
  output logic [30:0]          res_den,
  output logic                 res_lt,
  output logic                 res_eq,
  output logic                 res_gt,
  output logic [1:0]           res_st
);
  localparam logic [63:0] LIM = 64'd1 << (rau_pkg::WORD_BITS - 1);

  logic        sa_r, sb_r;
  logic [31:0] ma_r, mb_r, da_r, db_r;
  logic [63:0] x_r, y_r;           // gcd operands
  logic [6:0]  sh_r;               // common power of two
  logic [63:0] q_r, rem_r, dvd_r, dvs_r;
  logic [6:0]  cnt_r;
  logic [63:0] t1_r, t2_r, l_r, num_r, den_r, qa_r;
  logic        neg_r;
  logic [31:0] on_r;
  logic [30:0] od_r;
  logic        lt_r, eq_r, gt_r;
  logic [1:0]  st_r;

  logic [31:0] an, ad, bn, bd;
  assign an = in_a_num; assign ad = in_a_den; assign bn = in_b_num; assign bd = in_b_den;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  logic [63:0] xs, ys;
  logic [63:0] gcd_v;
  logic [64:0] rtry;
  assign rtry = {rem_r, dvd_r[63]} - {1'b0, dvs_r};
  // the odd part of the gcd ends up in whichever operand is still nonzero
  assign gcd_v = (x_r == 64'd0) ? y_r : x_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rau_pkg::OP_LOAD: begin
        ma_r <= mag32(an); mb_r <= mag32(bn);
        da_r <= mag32(ad); db_r <= mag32(bd);
        sa_r <= (an != 32'd0) && (an[31] != ad[31]);
        sb_r <= (bn != 32'd0) && ((bn[31] != bd[31]) ^ (in_action == rau_pkg::ACT_SUB));
        lt_r <= 1'b0; eq_r <= 1'b0; gt_r <= 1'b0;
        on_r <= '0; od_r <= 31'd1; st_r <= rau_pkg::ST_OK;
        if (in_action > rau_pkg::ACT_CMP) st_r <= rau_pkg::ST_OK;
        else if (ad == 32'd0 || bd == 32'd0 ||
                 (in_action == rau_pkg::ACT_DIV && bn == 32'd0)) st_r <= rau_pkg::ST_ZERO;
      end
      rau_pkg::OP_LDDEN: begin
        x_r <= {32'd0, da_r}; y_r <= {32'd0, db_r}; sh_r <= '0;
      end
      rau_pkg::OP_MUL1: begin
        // sel 0 mul/cmp cross, sel 1 div, sel 2 add/sub terms
        unique case (cmd.sel)
          2'd0: begin num_r <= ma_r * mb_r; den_r <= da_r * db_r;
                      t1_r <= ma_r * db_r; t2_r <= mb_r * da_r; end
          2'd1: begin num_r <= ma_r * db_r; den_r <= da_r * mb_r; end
          default: begin t1_r <= ma_r * q_r[31:0]; l_r <= qa_r[31:0] * db_r; end
        endcase
        neg_r <= (cmd.sel == 2'd1) ? (sa_r != sb_r) : (sa_r != sb_r);
      end
      rau_pkg::OP_MUL2: begin
        if (cmd.sel == 2'd0) begin
          lt_r <= (sa_r && !sb_r) || (sa_r && sb_r && t1_r > t2_r) ||
                  (!sa_r && !sb_r && t1_r < t2_r);
          eq_r <= (sa_r == sb_r) && (t1_r == t2_r);
          gt_r <= (!sa_r && sb_r) || (sa_r && sb_r && t1_r < t2_r) ||
                  (!sa_r && !sb_r && t1_r > t2_r);
        end else begin
          t2_r <= mb_r * qa_r[31:0];
        end
      end
      rau_pkg::OP_COMBINE: begin
        den_r <= l_r;
        if (sa_r == sb_r) begin num_r <= t1_r + t2_r; neg_r <= sa_r; end
        else if (t1_r >= t2_r) begin num_r <= t1_r - t2_r; neg_r <= sa_r; end
        else begin num_r <= t2_r - t1_r; neg_r <= sb_r; end
      end
      rau_pkg::OP_GCDINIT: begin
        if (cmd.sel == 2'd1) begin
          x_r <= num_r; y_r <= den_r; sh_r <= '0;
        end
      end
      rau_pkg::OP_GCDSTEP: begin
        // binary gcd: strip shared twos, then subtract odd values
        if (x_r == 64'd0) begin
          x_r <= y_r;
        end else if (y_r != 64'd0) begin
          if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1; y_r <= y_r >> 1; sh_r <= sh_r + 7'd1;
          end else if (!x_r[0]) x_r <= x_r >> 1;
          else if (!y_r[0]) y_r <= y_r >> 1;
          else if (x_r >= y_r) x_r <= (x_r - y_r) >> 1;
          else y_r <= (y_r - x_r) >> 1;
        end
      end
      rau_pkg::OP_DIVINIT: begin
        dvs_r <= gcd_v << sh_r;
        dvd_r <= (cmd.sel == 2'd0) ? {32'd0, da_r} : ((cmd.sel == 2'd1) ? {32'd0, db_r} :
                 ((cmd.sel == 2'd2) ? num_r : den_r));
        rem_r <= '0; cnt_r <= '0;
      end
      rau_pkg::OP_DIVSTEP: begin
        if (!rtry[64]) begin rem_r <= rtry[63:0]; dvd_r <= {dvd_r[62:0], 1'b1}; end
        else begin rem_r <= {rem_r[62:0], dvd_r[63]}; dvd_r <= {dvd_r[62:0], 1'b0}; end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          if (cmd.sel == 2'd0) qa_r <= {dvd_r[62:0], !rtry[64]};
          else if (cmd.sel == 2'd1) q_r <= {dvd_r[62:0], !rtry[64]};
          else if (cmd.sel == 2'd2) num_r <= {dvd_r[62:0], !rtry[64]};
          else den_r <= {dvd_r[62:0], !rtry[64]};
        end
      end
      rau_pkg::OP_PACK: begin
        if (den_r > LIM - 64'd1 || ((neg_r && num_r != 0) ? num_r > LIM : num_r > LIM - 64'd1))
        begin
          st_r <= rau_pkg::ST_OVF; on_r <= '0; od_r <= 31'd1;
        end else begin
          on_r <= (neg_r && num_r != 0) ? (32'd0 - num_r[31:0]) : num_r[31:0];
          od_r <= den_r[30:0];
        end
      end
      default: ;
    endcase
  end

  assign sts.gcd_done = (x_r == 64'd0) || (y_r == 64'd0);
  assign sts.div_done = (cnt_r == 7'd63);
  assign res_num = on_r;
  assign res_den = od_r;
  assign res_lt = lt_r;
  assign res_eq = eq_r;
  assign res_gt = gt_r;
  assign res_st = st_r;
  assign xs = x_r;
  assign ys = y_r;

  `include "rational_arithmetic_unit_defines.svh"
  `RAU_ASSERT_NEXT(a_cmp_onehot, clk, rst_n, cmd.op == rau_pkg::OP_MUL2 && cmd.sel == 2'd0, $onehot({lt_r, eq_r, gt_r}))
  `RAU_ASSERT_NEXT(a_gcd_shrinks, clk, rst_n, cmd.op == rau_pkg::OP_GCDSTEP && xs != 0 && ys != 0, (x_r <= $past(xs)) && (y_r <= $past(ys)))
  `RAU_ASSERT_NEXT(a_div_count, clk, rst_n, cmd.op == rau_pkg::OP_DIVINIT, cnt_r == 7'd0)
endmodule

// ===== rtl/rau_ctrl.sv =====
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_action,
  input  logic [31:0]   in_a_den,
  input  logic [31:0]   in_b_num,
  input  logic [31:0]   in_b_den,
  output logic          out_valid,
  input  logic          out_ready,
  output rau_pkg::cmd_t cmd,
  input  rau_pkg::sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEN = 4'd1, S_G1 = 4'd2, S_QA = 4'd3,
                         S_QB = 4'd4, S_M1 = 4'd5, S_M2 = 4'd6, S_CMB = 4'd7,
                         S_G2 = 4'd8, S_QN = 4'd9, S_QD = 4'd10, S_PACK = 4'd11,
                         S_OUT = 4'd12, S_CMP = 4'd13;
  localparam logic [1:0] PH_INIT = 2'd0, PH_RUN = 2'd1;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [2:0] act_r, act_nxt;

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; act_nxt = act_r;
    cmd.op = rau_pkg::OP_IDLE; cmd.sel = 2'd0;
    in_ready = (state_r == S_IDLE) && !out_valid;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.op = rau_pkg::OP_LOAD; act_nxt = in_action;
        if (in_action > rau_pkg::ACT_CMP || in_a_den == 32'd0 || in_b_den == 32'd0 ||
            (in_action == rau_pkg::ACT_DIV && in_b_num == 32'd0)) state_nxt = S_OUT;
        else if (in_action <= rau_pkg::ACT_SUB) state_nxt = S_DEN;
        else state_nxt = S_M1;
      end
      S_DEN: begin cmd.op = rau_pkg::OP_LDDEN; state_nxt = S_G1; end
      S_G1: if (sts.gcd_done) begin
        cmd.op = rau_pkg::OP_DIVINIT; cmd.sel = 2'd0; state_nxt = S_QA;
      end else cmd.op = rau_pkg::OP_GCDSTEP;
      S_QA: begin
        cmd.op = rau_pkg::OP_DIVSTEP; cmd.sel = 2'd0;
        if (sts.div_done) begin state_nxt = S_QB; ph_nxt = PH_INIT; end
      end
      S_QB: if (ph_r == PH_INIT) begin
        cmd.op = rau_pkg::OP_DIVINIT; cmd.sel = 2'd1; ph_nxt = PH_RUN;
      end else begin
        cmd.op = rau_pkg::OP_DIVSTEP; cmd.sel = 2'd1;
        if (sts.div_done) state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op = rau_pkg::OP_MUL1;
        cmd.sel = (act_r <= rau_pkg::ACT_SUB) ? 2'd2 :
                  ((act_r == rau_pkg::ACT_DIV) ? 2'd1 : 2'd0);
        state_nxt = (act_r <= rau_pkg::ACT_SUB) ? S_M2 :
                    ((act_r == rau_pkg::ACT_CMP) ? S_CMP : S_G2);
        ph_nxt = PH_INIT;
      end
      S_CMP: begin cmd.op = rau_pkg::OP_MUL2; cmd.sel = 2'd0; state_nxt = S_OUT; end
      S_M2: begin cmd.op = rau_pkg::OP_MUL2; cmd.sel = 2'd1; state_nxt = S_CMB; end
      S_CMB: begin cmd.op = rau_pkg::OP_COMBINE; state_nxt = S_G2; ph_nxt = PH_INIT; end
      S_G2: if (ph_r == PH_INIT) begin
        cmd.op = rau_pkg::OP_GCDINIT; cmd.sel = 2'd1; ph_nxt = PH_RUN;
      end else if (sts.gcd_done) begin
        cmd.op = rau_pkg::OP_DIVINIT; cmd.sel = 2'd2; state_nxt = S_QN;
      end else cmd.op = rau_pkg::OP_GCDSTEP;
      S_QN: begin
        cmd.op = rau_pkg::OP_DIVSTEP; cmd.sel = 2'd2;
        if (sts.div_done) begin state_nxt = S_QD; ph_nxt = PH_INIT; end
      end
      S_QD: if (ph_r == PH_INIT) begin
        cmd.op = rau_pkg::OP_DIVINIT; cmd.sel = 2'd3; ph_nxt = PH_RUN;
      end else begin
        cmd.op = rau_pkg::OP_DIVSTEP; cmd.sel = 2'd3;
        if (sts.div_done) state_nxt = S_PACK;
      end
      S_PACK: begin cmd.op = rau_pkg::OP_PACK; state_nxt = S_OUT; end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ph_r <= PH_INIT; act_r <= '0;
    end else begin
      state_r <= state_nxt; ph_r <= ph_nxt; act_r <= act_nxt;
    end
  end

  `include "rational_arithmetic_unit_defines.svh"
  `RAU_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready)
  `RAU_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `RAU_ASSERT_NEXT(a_idle_after_out, clk, rst_n, out_valid && out_ready, state_r == S_IDLE)
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready  | in_action, in_a_num, in_a_den, in_b_num, in_b_den
// out     | out_valid / out_ready| out_res_num, out_res_den, out_is_*, out_status
// One request at a time. A zero denominator, zero divisor or unused action goes straight
// to the output; compare runs no gcd, multiply/divide one binary gcd pass (reduction) and
// add/subtract two (denominators, then reduction), and the 64-step restoring divider runs
// twice per pass.
// Reset (rst_n low, synchronous) returns the controller to idle.
// A result holds on the output until taken; no new request is accepted meanwhile.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_is_less,
  output logic               out_is_equal,
  output logic               out_is_greater,
  output logic [1:0]         out_status
);
  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_a_den, .in_b_num, .in_b_den,
    .out_valid, .out_ready, .cmd, .sts
  );

  rau_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_action,
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .res_num(out_res_num), .res_den(out_res_den), .res_lt(out_is_less),
    .res_eq(out_is_equal), .res_gt(out_is_greater), .res_st(out_status)
  );
endmodule
